// ----- sv/dtq_pkg.sv -----
// ---------------------------------------------------------------------------
// dtq_pkg
// Shared constants, codes, entry types and the heap ordering function for
// the deadline timer heap queue.
// ---------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

  localparam int NUM_TIMERS = 32;
  localparam int HEAP_ARITY = 4;

  localparam int ID_W  = 5;
  localparam int DL_W  = 63;
  localparam int PER_W = 32;
  localparam int TAG_W = 32;

  localparam int IDX_W = $clog2(NUM_TIMERS);
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int KW    = $clog2(HEAP_ARITY);
  localparam int CH_W  = IDX_W + KW + 1;

  localparam logic [DL_W-1:0] NEVER = {DL_W{1'b1}};

  // input item kinds
  localparam logic [1:0] K_SET = 2'd0;
  localparam logic [1:0] K_DEL = 2'd1;
  localparam logic [1:0] K_CHK = 2'd2;

  // result kinds
  localparam logic [1:0] EV_FIRE = 2'd0;
  localparam logic [1:0] EV_SUM  = 2'd1;
  localparam logic [1:0] EV_ACK  = 2'd2;

  // heap entry: timer id plus its deadline
  typedef struct packed {
    logic [IDX_W-1:0] id;
    logic [DL_W-1:0]  dl;
  } hent_t;

  // per-timer entry
  typedef struct packed {
    logic [PER_W-1:0] period;
    logic [TAG_W-1:0] tag;
  } tent_t;

  // heap order: earlier deadline first, ties to the lower id
  function automatic logic earlier(hent_t a, hent_t b);
    return (a.dl < b.dl) || ((a.dl == b.dl) && (a.id < b.id));
  endfunction

endpackage

`default_nettype wire

// ----- sv/dtq_chan_if.sv -----
// ---------------------------------------------------------------------------
// dtq_in_if / dtq_out_if
// Valid/ready channels carrying the input items and the result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface dtq_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic [dtq_pkg::ID_W-1:0]  timer_id;
  logic [dtq_pkg::DL_W-1:0]  deadline;
  logic [dtq_pkg::PER_W-1:0] period;
  logic [dtq_pkg::TAG_W-1:0] tag;
  logic [dtq_pkg::DL_W-1:0]  now;

  modport source (output valid, kind, timer_id, deadline, period, tag, now, input ready);
  modport sink   (input valid, kind, timer_id, deadline, period, tag, now, output ready);
endinterface

interface dtq_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                event_res;
  logic [dtq_pkg::ID_W-1:0]  fired_id;
  logic [dtq_pkg::TAG_W-1:0] fired_tag;
  logic                      ok;
  logic [dtq_pkg::DL_W-1:0]  next_deadline;
  logic                      any_fired;
  logic                      last;

  modport source (output valid, event_res, fired_id, fired_tag, ok, next_deadline,
                  any_fired, last, input ready);
  modport sink   (input valid, event_res, fired_id, fired_tag, ok, next_deadline,
                  any_fired, last, output ready);
endinterface

`default_nettype wire

// ----- sv/dtq_ram.sv -----
// ---------------------------------------------------------------------------
// dtq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds until the next read.
// ---------------------------------------------------------------------------
`default_nettype none

module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- sv/dtq_reload.sv -----
// ---------------------------------------------------------------------------
// dtq_reload
// Periodic reload unit: computes now - ((now - deadline) mod period) + period
// with a bit-serial restoring remainder, saturating to never.
// ---------------------------------------------------------------------------
`default_nettype none

module dtq_reload (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [dtq_pkg::DL_W-1:0]  now_i,
  input  wire logic [dtq_pkg::DL_W-1:0]  dl_i,
  input  wire logic [dtq_pkg::PER_W-1:0] period_i,
  output logic                           done_o,
  output logic      [dtq_pkg::DL_W-1:0]  nw_o
);
  import dtq_pkg::*;

  localparam int BW = $clog2(DL_W);

  logic              busy_q, busy_d;
  logic              fin_q, fin_d;
  logic              done_q, done_d;
  logic [BW-1:0]     bit_q, bit_d;
  logic [DL_W-1:0]   dvd_q, dvd_d;
  logic [PER_W-1:0]  rem_q, rem_d;
  logic [PER_W-1:0]  per_q, per_d;
  logic [DL_W-1:0]   now_q, now_d;
  logic [DL_W-1:0]   nw_q, nw_d;
  logic [PER_W:0]    trial;
  logic [DL_W:0]     sum;

  // one remainder bit per cycle, then the final add and saturation
  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    bit_d  = bit_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    per_d  = per_q;
    now_d  = now_q;
    nw_d   = nw_q;
    trial  = {rem_q, dvd_q[DL_W-1]};
    sum    = {1'b0, now_q} + (DL_W+1)'(per_q) - (DL_W+1)'(rem_q);
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = '0;
      dvd_d  = now_i - dl_i;
      rem_d  = '0;
      per_d  = period_i;
      now_d  = now_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, per_q}) begin
        rem_d = PER_W'(trial - {1'b0, per_q});
      end else begin
        rem_d = trial[PER_W-1:0];
      end
      dvd_d = {dvd_q[DL_W-2:0], 1'b0};
      bit_d = bit_q + 1'b1;
      if (bit_q == BW'(DL_W - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      nw_d   = (sum >= {1'b0, NEVER}) ? NEVER : sum[DL_W-1:0];
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      per_q  <= '0;
      now_q  <= '0;
      nw_q   <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      bit_q  <= bit_d;
      dvd_q  <= dvd_d;
      rem_q  <= rem_d;
      per_q  <= per_d;
      now_q  <= now_d;
      nw_q   <= nw_d;
    end
  end

  assign done_o = done_q;
  assign nw_o   = nw_q;

`ifndef SYNTHESIS
  a_rem_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i) |-> (rem_q < per_q || per_q == '0))
    else $error("reload remainder not below period");
  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(fin_q))
    else $error("reload done without final step");
  a_result_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ((nw_q > now_q) || (nw_q == NEVER)))
    else $error("reload deadline not after now");
`endif

endmodule

`default_nettype wire

// ----- sv/deadline_timer_heap_queue_top.sv -----
// ---------------------------------------------------------------------------
// deadline_timer_heap_queue_top
// Timer queue over a 4-ary min-heap of deadlines held in synchronous RAM.
//
// Channels: in_i takes set, delete and check items; out_o returns results,
// the final one of each item marked with last. Transfers complete on
// valid and ready high at a rising edge.
// One item is worked at a time; in_i is ready only while no item is at work.
// The last result sits in the output register while the next item is taken.
// Set and delete walk each heap level up through ST_UP and ST_UP_CMP and
// each level down through ST_DN, ST_DN_CMP and ST_DN_DEC (one child read
// per cycle). A check does, per fired timer, its heap repair; a periodic
// timer also passes through the bit-serial remainder unit that computes
// its next deadline.
// Reset empties the queue and disarms all timers at once; no clearing pass.
// A stalled receiver holds the block in the emitting state until the
// pending result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module deadline_timer_heap_queue_top (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  dtq_in_if.sink    in_i,
  dtq_out_if.source out_o
);
  import dtq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SET, ST_DEL, ST_MOVE, ST_UP, ST_UP_CMP, ST_DN, ST_DN_CMP,
    ST_DN_DEC, ST_ACK, ST_CHK, ST_CHK_TOP, ST_FIRE, ST_RELOAD, ST_SUM
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        kind_q, kind_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [DL_W-1:0]   dl_q, dl_d;
  logic [PER_W-1:0]  per_q, per_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [DL_W-1:0]   now_q, now_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [NUM_TIMERS-1:0] active_q, active_d;
  logic [IDX_W-1:0]  hpos_q [NUM_TIMERS];
  hent_t             x_q, x_d;
  hent_t             best_q, best_d;
  hent_t             top_q, top_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  par_q, par_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  bpos_q, bpos_d;
  logic [KW-1:0]     k_q, k_d;
  logic [CNT_W-1:0]  fcnt_q, fcnt_d;
  logic              any_q, any_d;
  logic              okf_q, okf_d;
  logic [DL_W-1:0]   nd_q, nd_d;

  logic              ov_q, ov_d;
  logic [1:0]        oev_q, oev_d;
  logic [ID_W-1:0]   oid_q, oid_d;
  logic [TAG_W-1:0]  otag_q, otag_d;
  logic              ook_q, ook_d;
  logic [DL_W-1:0]   ond_q, ond_d;
  logic              oany_q, oany_d;
  logic              olast_q, olast_d;

  logic              hpos_we;
  logic [IDX_W-1:0]  hpos_wa, hpos_wd;

  logic              h_we, h_re;
  logic [IDX_W-1:0]  h_wa, h_ra;
  hent_t             h_wd, h_rd;
  logic              t_we, t_re;
  logic [IDX_W-1:0]  t_wa, t_ra;
  tent_t             t_wd, t_rd;

  logic              rl_start, rl_done;
  logic [DL_W-1:0]   rl_nw;

  logic [IDX_W-1:0]  idx;
  logic              id_ok;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CH_W-1:0]   child0, nxt;
  logic              out_free;
  state_e            after_sift;

  assign idx        = IDX_W'(id_q);
  assign id_ok      = ({1'b0, id_q} < (ID_W+1)'(NUM_TIMERS));
  assign cnt_m1     = cnt_q - 1'b1;
  assign child0     = CH_W'(pos_q) * CH_W'(HEAP_ARITY) + CH_W'(1);
  assign nxt        = CH_W'(cur_q) + CH_W'(1);
  assign out_free   = !ov_q || out_o.ready;
  assign after_sift = (kind_q == K_CHK) ? ST_CHK : ST_ACK;
  assign in_i.ready = (state_q == ST_IDLE);

  dtq_ram #(.WIDTH($bits(hent_t)), .DEPTH(NUM_TIMERS)) u_heap_ram (
    .clk_i, .wr_en_i(h_we), .wr_addr_i(h_wa), .wr_data_i(h_wd),
    .rd_en_i(h_re), .rd_addr_i(h_ra), .rd_data_o(h_rd)
  );

  dtq_ram #(.WIDTH($bits(tent_t)), .DEPTH(NUM_TIMERS)) u_timer_ram (
    .clk_i, .wr_en_i(t_we), .wr_addr_i(t_wa), .wr_data_i(t_wd),
    .rd_en_i(t_re), .rd_addr_i(t_ra), .rd_data_o(t_rd)
  );

  dtq_reload u_reload (
    .clk_i, .rst_ni, .start_i(rl_start), .now_i(now_q), .dl_i(top_q.dl),
    .period_i(t_rd.period), .done_o(rl_done), .nw_o(rl_nw)
  );

  // sequencer: sift through heap memory, fire due timers, emit results
  always_comb begin
    state_d = state_q;
    kind_d = kind_q; id_d = id_q; dl_d = dl_q; per_d = per_q; tag_d = tag_q;
    now_d = now_q;
    cnt_d = cnt_q; active_d = active_q;
    x_d = x_q; best_d = best_q; top_d = top_q;
    pos_d = pos_q; par_d = par_q; cur_d = cur_q; bpos_d = bpos_q; k_d = k_q;
    fcnt_d = fcnt_q; any_d = any_q; okf_d = okf_q; nd_d = nd_q;
    ov_d = ov_q && !out_o.ready;
    oev_d = oev_q; oid_d = oid_q; otag_d = otag_q; ook_d = ook_q;
    ond_d = ond_q; oany_d = oany_q; olast_d = olast_q;
    hpos_we = 1'b0; hpos_wa = '0; hpos_wd = '0;
    h_we = 1'b0; h_wa = '0; h_wd = '0; h_re = 1'b0; h_ra = '0;
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_re = 1'b0; t_ra = '0;
    rl_start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          kind_d = in_i.kind; id_d = in_i.timer_id; dl_d = in_i.deadline;
          per_d = in_i.period; tag_d = in_i.tag; now_d = in_i.now;
          priority case (in_i.kind)
            K_SET: state_d = ST_SET;
            K_DEL: state_d = ST_DEL;
            K_CHK: begin
              fcnt_d  = '0;
              any_d   = 1'b0;
              state_d = ST_CHK;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SET: begin
        if (id_ok) begin
          t_we = 1'b1; t_wa = idx; t_wd = '{period: per_q, tag: tag_q};
          x_d = '{id: idx, dl: dl_q};
          okf_d = 1'b1;
          if (active_q[idx]) begin
            pos_d = hpos_q[idx];
          end else begin
            active_d[idx] = 1'b1;
            pos_d = cnt_q[IDX_W-1:0];
            cnt_d = cnt_q + 1'b1;
          end
          state_d = ST_UP;
        end else begin
          okf_d = 1'b0;
          state_d = ST_ACK;
        end
      end
      ST_DEL: begin
        if (id_ok && active_q[idx]) begin
          okf_d = 1'b1;
          active_d[idx] = 1'b0;
          cnt_d = cnt_m1;
          pos_d = hpos_q[idx];
          if (CNT_W'(hpos_q[idx]) >= cnt_m1) begin
            state_d = ST_ACK;
          end else begin
            h_re = 1'b1; h_ra = cnt_m1[IDX_W-1:0];
            state_d = ST_MOVE;
          end
        end else begin
          okf_d = 1'b0;
          state_d = ST_ACK;
        end
      end
      // take the last entry into the hole
      ST_MOVE: begin
        x_d = h_rd;
        state_d = ST_UP;
      end
      ST_UP: begin
        if (pos_q == '0) begin
          state_d = ST_DN;
        end else begin
          par_d = IDX_W'((pos_q - 1'b1) / HEAP_ARITY);
          h_re = 1'b1; h_ra = IDX_W'((pos_q - 1'b1) / HEAP_ARITY);
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (earlier(x_q, h_rd)) begin
          h_we = 1'b1; h_wa = pos_q; h_wd = h_rd;
          hpos_we = 1'b1; hpos_wa = h_rd.id; hpos_wd = pos_q;
          pos_d = par_q;
          state_d = ST_UP;
        end else begin
          state_d = ST_DN;
        end
      end
      ST_DN: begin
        if (child0 >= CH_W'(cnt_q)) begin
          h_we = 1'b1; h_wa = pos_q; h_wd = x_q;
          hpos_we = 1'b1; hpos_wa = x_q.id; hpos_wd = pos_q;
          state_d = after_sift;
        end else begin
          h_re = 1'b1; h_ra = child0[IDX_W-1:0];
          cur_d = child0[IDX_W-1:0];
          k_d = '0;
          state_d = ST_DN_CMP;
        end
      end
      // scan the children one read at a time
      ST_DN_CMP: begin
        if (k_q == '0 || earlier(h_rd, best_q)) begin
          best_d = h_rd;
          bpos_d = cur_q;
        end
        if (k_q != KW'(HEAP_ARITY - 1) && nxt < CH_W'(cnt_q)) begin
          h_re = 1'b1; h_ra = nxt[IDX_W-1:0];
          cur_d = nxt[IDX_W-1:0];
          k_d = k_q + 1'b1;
        end else begin
          state_d = ST_DN_DEC;
        end
      end
      ST_DN_DEC: begin
        if (earlier(best_q, x_q)) begin
          h_we = 1'b1; h_wa = pos_q; h_wd = best_q;
          hpos_we = 1'b1; hpos_wa = best_q.id; hpos_wd = pos_q;
          pos_d = bpos_q;
          state_d = ST_DN;
        end else begin
          h_we = 1'b1; h_wa = pos_q; h_wd = x_q;
          hpos_we = 1'b1; hpos_wa = x_q.id; hpos_wd = pos_q;
          state_d = after_sift;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          ov_d = 1'b1; oev_d = EV_ACK; oid_d = id_q; otag_d = '0; ook_d = okf_q;
          ond_d = '0; oany_d = 1'b0; olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CHK: begin
        if (cnt_q == '0) begin
          nd_d = '0;
          state_d = ST_SUM;
        end else begin
          h_re = 1'b1; h_ra = '0;
          state_d = ST_CHK_TOP;
        end
      end
      ST_CHK_TOP: begin
        top_d = h_rd;
        if (fcnt_q == CNT_W'(NUM_TIMERS) || h_rd.dl == NEVER || h_rd.dl > now_q) begin
          nd_d = h_rd.dl;
          state_d = ST_SUM;
        end else begin
          t_re = 1'b1; t_ra = h_rd.id;
          state_d = ST_FIRE;
        end
      end
      ST_FIRE: begin
        if (out_free) begin
          ov_d = 1'b1; oev_d = EV_FIRE; oid_d = ID_W'(top_q.id); otag_d = t_rd.tag;
          ook_d = 1'b0; ond_d = '0; oany_d = 1'b0; olast_d = 1'b0;
          fcnt_d = fcnt_q + 1'b1;
          any_d = 1'b1;
          if (t_rd.period != '0) begin
            rl_start = 1'b1;
            state_d = ST_RELOAD;
          end else begin
            active_d[top_q.id] = 1'b0;
            cnt_d = cnt_m1;
            pos_d = '0;
            if (cnt_m1 == '0) begin
              state_d = ST_CHK;
            end else begin
              h_re = 1'b1; h_ra = cnt_m1[IDX_W-1:0];
              state_d = ST_MOVE;
            end
          end
        end
      end
      ST_RELOAD: begin
        if (rl_done) begin
          x_d = '{id: top_q.id, dl: rl_nw};
          pos_d = '0;
          state_d = ST_DN;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          ov_d = 1'b1; oev_d = EV_SUM; oid_d = '0; otag_d = '0; ook_d = 1'b0;
          ond_d = nd_q; oany_d = any_q; olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q <= '0; id_q <= '0; dl_q <= '0; per_q <= '0; tag_q <= '0; now_q <= '0;
      cnt_q <= '0; active_q <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        hpos_q[i] <= '0;
      end
      x_q <= '0; best_q <= '0; top_q <= '0;
      pos_q <= '0; par_q <= '0; cur_q <= '0; bpos_q <= '0; k_q <= '0;
      fcnt_q <= '0; any_q <= 1'b0; okf_q <= 1'b0; nd_q <= '0;
      ov_q <= 1'b0; oev_q <= '0; oid_q <= '0; otag_q <= '0; ook_q <= 1'b0;
      ond_q <= '0; oany_q <= 1'b0; olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q <= kind_d; id_q <= id_d; dl_q <= dl_d; per_q <= per_d; tag_q <= tag_d;
      now_q <= now_d;
      cnt_q <= cnt_d; active_q <= active_d;
      if (hpos_we) begin
        hpos_q[hpos_wa] <= hpos_wd;
      end
      x_q <= x_d; best_q <= best_d; top_q <= top_d;
      pos_q <= pos_d; par_q <= par_d; cur_q <= cur_d; bpos_q <= bpos_d; k_q <= k_d;
      fcnt_q <= fcnt_d; any_q <= any_d; okf_q <= okf_d; nd_q <= nd_d;
      ov_q <= ov_d; oev_q <= oev_d; oid_q <= oid_d; otag_q <= otag_d; ook_q <= ook_d;
      ond_q <= ond_d; oany_q <= oany_d; olast_q <= olast_d;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.event_res     = oev_q;
  assign out_o.fired_id      = oid_q;
  assign out_o.fired_tag     = otag_q;
  assign out_o.ok            = ook_q;
  assign out_o.next_deadline = ond_q;
  assign out_o.any_fired     = oany_q;
  assign out_o.last          = olast_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CNT_W'(NUM_TIMERS)) && (fcnt_q <= CNT_W'(NUM_TIMERS)))
    else $error("heap or fire count out of range");
  a_count_matches_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(active_q) == int'(cnt_q)))
    else $error("heap count differs from armed timers");
  a_no_mem_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(h_we && h_re && h_wa == h_ra))
    else $error("heap read and write collide");
  a_reload_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rl_done |-> ((rl_nw > now_q) || (rl_nw == NEVER)))
    else $error("reloaded deadline not after now");
`endif

endmodule

`default_nettype wire
